// File: rtl/core/ggt_pkg.sv
package ggt_pkg;

  localparam int GAMMA_FRAC_BITS_DEF = 12;

  // luma weights, Q8.8
  localparam logic [15:0] LUMA_WR = 16'd77;
  localparam logic [15:0] LUMA_WG = 16'd151;
  localparam logic [15:0] LUMA_WB = 16'd28;

  // configuration register indexes
  localparam logic [1:0] CFG_GAMMA = 2'd0;
  localparam logic [1:0] CFG_TINT_B = 2'd1;
  localparam logic [1:0] CFG_TINT_G = 2'd2;
  localparam logic [1:0] CFG_TINT_R = 2'd3;

  localparam logic [15:0] GAMMA_RST = 16'd5734;
  localparam logic [8:0] TINT_B_RST = 9'd0;
  localparam logic [8:0] TINT_G_RST = 9'd192;
  localparam logic [8:0] TINT_R_RST = 9'd0;

  typedef struct packed {
    logic        valid;
    logic [15:0] luma;
  } ggt_lg_in_t;

  typedef struct packed {
    logic        valid;
    logic        zero;
    logic [19:0] lg;     // signed Q16 log2
  } ggt_lg_out_t;

  // 2^(k/16) in Q16
  function automatic logic [17:0] exp2_lut(input logic [4:0] k);
    logic [17:0] v;
    case (k)
      5'd0:  v = 18'd65536;
      5'd1:  v = 18'd68438;
      5'd2:  v = 18'd71468;
      5'd3:  v = 18'd74632;
      5'd4:  v = 18'd77936;
      5'd5:  v = 18'd81386;
      5'd6:  v = 18'd84990;
      5'd7:  v = 18'd88752;
      5'd8:  v = 18'd92682;
      5'd9:  v = 18'd96785;
      5'd10: v = 18'd101070;
      5'd11: v = 18'd105545;
      5'd12: v = 18'd110219;
      5'd13: v = 18'd115098;
      5'd14: v = 18'd120194;
      5'd15: v = 18'd125515;
      5'd16: v = 18'd131072;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/ggt_in_if.sv
interface ggt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;

  modport source (output valid, blue_in, green_in, red_in, input ready);
  modport sink (input valid, blue_in, green_in, red_in, output ready);
  modport monitor (input valid, ready, blue_in, green_in, red_in);
endinterface

// File: rtl/core/ggt_out_if.sv
interface ggt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;

  modport source (output valid, blue_out, green_out, red_out, input ready);
  modport sink (input valid, blue_out, green_out, red_out, output ready);
  modport monitor (input valid, ready, blue_out, green_out, red_out);
endinterface

// File: rtl/core/ggt_log2.sv
module ggt_log2 (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ggt_pkg::ggt_lg_in_t  lg_in,
  output ggt_pkg::ggt_lg_out_t lg_out
);

  localparam int NSQ = 16;

  logic [15:0] m_r    [0:NSQ];
  logic [15:0] frac_r [0:NSQ];
  logic [3:0]  p_r    [0:NSQ];
  logic        z_r    [0:NSQ];
  logic        v_r    [0:NSQ];

  logic [3:0]  p_nxt;
  logic [15:0] m_nxt;

  // leading one and normalize to Q15
  always_comb begin
    p_nxt = 4'd0;
    for (int k = 0; k < 16; k++) begin
      if (lg_in.luma[k]) p_nxt = 4'(k);
    end
    m_nxt = 16'(lg_in.luma << (4'd15 - p_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= lg_in.valid;
    end
    if (en) begin
      m_r[0]    <= m_nxt;
      p_r[0]    <= p_nxt;
      z_r[0]    <= (lg_in.luma == 16'd0);
      frac_r[0] <= 16'd0;
    end
  end

  // one squaring per stage, one fraction bit each
  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    logic [31:0] sq;
    logic [16:0] t;
    assign sq = 32'(m_r[i]) * 32'(m_r[i]);
    assign t  = sq[31:15];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
      if (en) begin
        m_r[i+1]    <= t[16] ? t[16:1] : t[15:0];
        frac_r[i+1] <= {frac_r[i][14:0], t[16]};
        p_r[i+1]    <= p_r[i];
        z_r[i+1]    <= z_r[i];
      end
    end
  end

  // integer part p-8 as 4-bit two's complement
  assign lg_out.valid = v_r[NSQ];
  assign lg_out.zero  = z_r[NSQ];
  assign lg_out.lg    = {~p_r[NSQ][3], p_r[NSQ][2:0], frac_r[NSQ]};

endmodule

// File: rtl/core/gray_gamma_tint_pixel.sv
// Throughput: one pixel per clock; the whole pipeline advances together and
// holds while the result register is full and not taken.
// Log2 takes 17 stages (normalize plus one squaring multiplier per stage).
// Reset (rst_n low, synchronous) empties the pipeline and loads default config.
module gray_gamma_tint_pixel #(
  parameter int GAMMA_FRAC_BITS = ggt_pkg::GAMMA_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ggt_in_if.sink      in_if,
  ggt_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] gamma_r;
  logic [8:0]  tint_b_r, tint_g_r, tint_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r  <= ggt_pkg::GAMMA_RST;
      tint_b_r <= ggt_pkg::TINT_B_RST;
      tint_g_r <= ggt_pkg::TINT_G_RST;
      tint_r_r <= ggt_pkg::TINT_R_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ggt_pkg::CFG_GAMMA:  gamma_r  <= cfg_wdata;
        ggt_pkg::CFG_TINT_B: tint_b_r <= cfg_wdata[8:0];
        ggt_pkg::CFG_TINT_G: tint_g_r <= cfg_wdata[8:0];
        ggt_pkg::CFG_TINT_R: tint_r_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  // stage: luma
  logic        luma_v_r;
  logic [15:0] luma_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      luma_v_r <= 1'b0;
    end else if (en) begin
      luma_v_r <= in_if.valid;
    end
    if (en) begin
      luma_r <= 16'(ggt_pkg::LUMA_WR * {8'd0, in_if.red_in})
              + 16'(ggt_pkg::LUMA_WG * {8'd0, in_if.green_in})
              + 16'(ggt_pkg::LUMA_WB * {8'd0, in_if.blue_in});
    end
  end

  ggt_pkg::ggt_lg_in_t  lg_in;
  ggt_pkg::ggt_lg_out_t lg_out;
  assign lg_in.valid = luma_v_r;
  assign lg_in.luma  = luma_r;

  ggt_log2 u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .lg_in  (lg_in),
    .lg_out (lg_out)
  );

  // stage: log * gamma
  logic               e_v_r, e_z_r;
  logic signed [35:0] e_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= lg_out.valid;
    end
    if (en) begin
      e_z_r <= lg_out.zero;
      e_r   <= 36'(signed'(lg_out.lg)) * 36'(signed'({1'b0, gamma_r}));
    end
  end

  // stage: floor to Q16, range check, table lookup
  logic signed [35:0] q, qq;
  assign q  = e_r >>> GAMMA_FRAC_BITS;
  assign qq = q + 36'sd1048576;

  logic        x_v_r, x_z_r, x_hi_r, x_lo_r;
  logic [4:0]  x_int_r;
  logic [11:0] x_rr_r;
  logic [17:0] x_base_r;
  logic [12:0] x_diff_r;
  logic [17:0] lut_a, lut_b;
  assign lut_a = ggt_pkg::exp2_lut({1'b0, qq[15:12]});
  assign lut_b = ggt_pkg::exp2_lut(5'({1'b0, qq[15:12]} + 5'd1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_v_r <= 1'b0;
    end else if (en) begin
      x_v_r <= e_v_r;
    end
    if (en) begin
      x_z_r    <= e_z_r;
      x_hi_r   <= (q >= 36'sd524288);
      x_lo_r   <= (q < -36'sd1048576);
      x_int_r  <= qq[20:16];
      x_rr_r   <= qq[11:0];
      x_base_r <= lut_a;
      x_diff_r <= 13'(lut_b - lut_a);
    end
  end

  // stage: interpolate
  logic        m_v_r, m_z_r, m_hi_r, m_lo_r;
  logic [4:0]  m_int_r;
  logic [17:0] mant_r;
  logic [24:0] ip;
  assign ip = 25'(x_diff_r) * 25'(x_rr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= x_v_r;
    end
    if (en) begin
      m_z_r   <= x_z_r;
      m_hi_r  <= x_hi_r;
      m_lo_r  <= x_lo_r;
      m_int_r <= x_int_r;
      mant_r  <= x_base_r + 18'(ip[24:12]);
    end
  end

  // stage: scale and clamp to gray level
  logic [5:0]  sh;
  logic [17:0] res;
  logic [7:0]  gray_nxt;
  assign sh  = 6'd32 - {1'b0, m_int_r};
  assign res = mant_r >> sh;

  always_comb begin
    if (m_z_r)                gray_nxt = (gamma_r == 16'd0) ? 8'd1 : 8'd0;
    else if (m_hi_r)          gray_nxt = 8'd255;
    else if (m_lo_r)          gray_nxt = 8'd0;
    else if (m_int_r < 5'd15) gray_nxt = 8'd0;  // shift beyond 17
    else if (res > 18'd255)   gray_nxt = 8'd255;
    else                      gray_nxt = res[7:0];
  end

  logic       g_v_r;
  logic [7:0] gray_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (en) begin
      g_v_r <= m_v_r;
    end
    if (en) begin
      gray_r <= gray_nxt;
    end
  end

  // stage: tint, output register
  logic [7:0] inv;
  logic [16:0] pb, pg, pr;
  logic [9:0]  sb, sg, sr;
  assign inv = 8'd255 - gray_r;
  assign pb  = 17'(inv) * 17'(tint_b_r);
  assign pg  = 17'(inv) * 17'(tint_g_r);
  assign pr  = 17'(inv) * 17'(tint_r_r);
  assign sb  = 10'(gray_r) + 10'(pb[16:8]);
  assign sg  = 10'(gray_r) + 10'(pg[16:8]);
  assign sr  = 10'(gray_r) + 10'(pr[16:8]);

  logic       o_v_r;
  logic [7:0] ob_r, og_r, or_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r <= g_v_r;
    end
    if (en) begin
      ob_r <= (sb > 10'd255) ? 8'd255 : sb[7:0];
      og_r <= (sg > 10'd255) ? 8'd255 : sg[7:0];
      or_r <= (sr > 10'd255) ? 8'd255 : sr[7:0];
    end
  end

  assign out_if.valid     = o_v_r;
  assign out_if.blue_out  = ob_r;
  assign out_if.green_out = og_r;
  assign out_if.red_out   = or_r;

endmodule

// File: sim/ggt_checker.sv
`timescale 1ns / 100ps

module ggt_checker #(
  parameter int GAMMA_FRAC_BITS = ggt_pkg::GAMMA_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ggt_in_if.monitor   in_mon,
  ggt_out_if.monitor  out_mon,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  logic [15:0] gamma_q;
  logic [8:0]  tint_b, tint_g, tint_r;
  pixel_t      tinted_q[$];

  assign pending = tinted_q.size();

  function automatic longint luma_log2(int unsigned u);
    int unsigned p;
    longint unsigned m;
    int unsigned frac;
    p = 0;
    frac = 0;
    while (p < 15 && (u >> (p + 1)) != 0) p++;
    m = longint'(u) << (15 - p);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 15;
      frac = frac << 1;
      if (m >= 65536) begin
        frac |= 1;
        m = m >> 1;
      end
    end
    return (longint'(p) - 8) * 65536 + longint'(frac);
  endfunction

  function automatic int unsigned gray_level(int unsigned luma);
    longint e, q, n, sh;
    longint unsigned qq, f, idx, r, lo, hi, mant, res;
    if (luma == 0) return (gamma_q == 0) ? 1 : 0;
    e = luma_log2(luma) * longint'(gamma_q);
    if (e >= 0) q = e >>> GAMMA_FRAC_BITS;
    else q = -(((-e) + ((longint'(1) << GAMMA_FRAC_BITS) - 1)) >>> GAMMA_FRAC_BITS);
    if (q >= 8 * 65536) return 255;
    if (q < -16 * 65536) return 0;
    qq = q + 16 * 65536;
    n = longint'(qq >> 16) - 16;
    f = qq & 16'hFFFF;
    idx = f >> 12;
    r = f & 12'hFFF;
    lo = ggt_pkg::exp2_lut(idx[4:0]);
    hi = ggt_pkg::exp2_lut(idx[4:0] + 5'd1);
    mant = lo + (((hi - lo) * r) >> 12);
    sh = 16 - n;
    if (sh > 17) return 0;
    res = mant >> sh;
    return (res > 255) ? 255 : 32'(res);
  endfunction

  function automatic logic [7:0] tint_toward_white(int unsigned g, logic [8:0] t);
    int unsigned v;
    v = g + (((255 - g) * t) >> 8);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  always @(posedge clk) begin
    pixel_t exp_px, got_px;
    int unsigned luma, g;
    if (!rst_n) begin
      gamma_q <= ggt_pkg::GAMMA_RST;
      tint_b <= ggt_pkg::TINT_B_RST;
      tint_g <= ggt_pkg::TINT_G_RST;
      tint_r <= ggt_pkg::TINT_R_RST;
      fail_count <= 0;
      tinted_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        luma = 77 * in_mon.red_in + 151 * in_mon.green_in + 28 * in_mon.blue_in;
        g = gray_level(luma);
        exp_px.blue = tint_toward_white(g, tint_b);
        exp_px.green = tint_toward_white(g, tint_g);
        exp_px.red = tint_toward_white(g, tint_r);
        tinted_q.insert(tinted_q.size(), exp_px);
      end
      if (out_mon.valid && out_mon.ready) begin
        got_px = {out_mon.blue_out, out_mon.green_out, out_mon.red_out};
        if (tinted_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected transaction %h", got_px);
          fail_count <= fail_count + 1;
        end else begin
          exp_px = tinted_q.pop_front();
          if (got_px !== exp_px) begin
            if (fail_count < 10)
              $display("mismatch: exp b=%0d g=%0d r=%0d got b=%0d g=%0d r=%0d",
                       exp_px.blue, exp_px.green, exp_px.red,
                       got_px.blue, got_px.green, got_px.red);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          ggt_pkg::CFG_GAMMA:  gamma_q <= cfg_wdata;
          ggt_pkg::CFG_TINT_B: tint_b <= cfg_wdata[8:0];
          ggt_pkg::CFG_TINT_G: tint_g <= cfg_wdata[8:0];
          ggt_pkg::CFG_TINT_R: tint_r <= cfg_wdata[8:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// File: sim/gray_gamma_tint_pixel_test.sv
`timescale 1ns / 100ps

module gray_gamma_tint_pixel_test;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          idle_pct;
  int          stall_pct;
  logic        in_taken;

  ggt_in_if  in_ch();
  ggt_out_if out_ch();

  gray_gamma_tint_pixel u_dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  ggt_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.monitor), .out_mon(out_ch.monitor),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver stalls at random
  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  // input handshake as seen at the rising edge
  always @(posedge clk) in_taken <= in_ch.valid && in_ch.ready;

  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.blue_in <= b;
    in_ch.green_in <= g;
    in_ch.red_in <= r;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic set_all(input logic [15:0] gam, input logic [8:0] tb,
                         input logic [8:0] tg, input logic [8:0] tr);
    drain();
    write_reg(ggt_pkg::CFG_GAMMA, gam);
    write_reg(ggt_pkg::CFG_TINT_B, {7'd0, tb});
    write_reg(ggt_pkg::CFG_TINT_G, {7'd0, tg});
    write_reg(ggt_pkg::CFG_TINT_R, {7'd0, tr});
    cfg_we <= 1'b0;
  endtask

  task automatic random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0)
        send_pixel($urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
                   $urandom_range(1) ? 8'hFF : 8'h00);
      else if ($urandom_range(4) == 0)
        send_pixel(8'($urandom_range(3)), 8'($urandom_range(3)), 8'($urandom_range(3)));
      else
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int pct_set[4][2];
    pct_set = '{'{0, 0}, '{67, 0}, '{0, 67}, '{33, 33}};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.blue_in = '0;
    in_ch.green_in = '0;
    in_ch.red_in = '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: default config, extremes, zero luma, tiny luma
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);
    // zero exponent: gray is 1 everywhere
    set_all(16'd0, 9'd256, 9'd0, 9'd511);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd200, 8'd10, 8'd99);
    // huge exponent: saturation and power below one
    set_all(16'hFFFF, 9'd128, 9'd256, 9'd300);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd3, 8'd2, 8'd1);
    // unit exponent, no tint
    set_all(16'd4096, 9'd0, 9'd0, 9'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd100, 8'd100, 8'd100);
    send_pixel(8'd1, 8'd1, 8'd1);
    // out-of-range register index does not exist on a 2-bit address

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      idle_pct = pct_set[ph % 4][0];
      stall_pct = pct_set[ph % 4][1];
      case (ph)
        0: set_all(16'd5734, 9'd0, 9'd192, 9'd0);
        1: set_all(16'd2048, 9'd256, 9'd64, 9'd511);
        2: set_all(16'd8192, 9'd1, 9'd255, 9'd128);
        3: set_all(16'd1, 9'd256, 9'd256, 9'd256);
        4: set_all(16'd12000, 9'd0, 9'd0, 9'd0);
        5: set_all(16'hFFFF, 9'd300, 9'd1, 9'd200);
        default: set_all(16'($urandom), 9'($urandom_range(511)), 9'($urandom_range(511)),
                         9'($urandom_range(511)));
      endcase
      random_pixels(178);
    end

    drain();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
